// ----- sv/txcmd_pkg.sv -----
// Package for the text command field parser.
// Holds character codes, command codes, keyword tables and the result bundle.
// No dependencies.
package txcmd_pkg;

	localparam int MAX_MESSAGE_LEN_DEF = 100;
	localparam int MIN_MESSAGE_LEN     = 5;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_SEP  = 8'h5F;  // underscore
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_H    = 8'h68;
	localparam logic [7:0] CH_K    = 8'h6B;
	localparam logic [7:0] CH_M    = 8'h6D;
	localparam logic [7:0] CH_Z    = 8'h7A;

	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_SEND    = 3'd1;
	localparam logic [2:0] CMD_RECEIVE = 3'd2;
	localparam logic [2:0] CMD_STOP    = 3'd3;
	localparam logic [2:0] CMD_QUERY   = 3'd4;

	localparam int NUM_KW = 4;

	localparam logic [1:0] SEG_CMD  = 2'd0;
	localparam logic [1:0] SEG_FREQ = 2'd1;
	localparam logic [1:0] SEG_DUR  = 2'd2;
	localparam logic [1:0] SEG_DONE = 2'd3;

	localparam logic [19:0] SCALE_ONE  = 20'd1;
	localparam logic [19:0] SCALE_KHZ  = 20'd1000;
	localparam logic [19:0] SCALE_MHZ  = 20'd1000000;

	// Unit flags of the frequency token
	localparam int UNIT_KHZ_BIT = 0;
	localparam int UNIT_MHZ_BIT = 1;

	typedef struct packed {
		logic [2:0]  command_code;
		logic [31:0] freq_raw;
		logic [1:0]  freq_unit;
		logic [31:0] duration_value;
	} txcmd_result_t;

	// Keyword length
	function automatic logic [3:0] kw_len(input logic [1:0] k);
		logic [3:0] len;
		case (k)
			2'd0:    len = 4'd4;
			2'd1:    len = 4'd7;
			2'd2:    len = 4'd4;
			2'd3:    len = 4'd5;
			default: len = 4'd0;
		endcase
		return len;
	endfunction

	// Command code that a keyword stands for
	function automatic logic [2:0] kw_code(input logic [1:0] k);
		logic [2:0] code;
		case (k)
			2'd0:    code = CMD_SEND;
			2'd1:    code = CMD_RECEIVE;
			2'd2:    code = CMD_STOP;
			2'd3:    code = CMD_QUERY;
			default: code = CMD_NONE;
		endcase
		return code;
	endfunction

	// Keyword character at a position; zero past the end
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		case (k)
			2'd0: begin
				case (pos)
					3'd0:    ch = 8'h73; // s
					3'd1:    ch = 8'h65; // e
					3'd2:    ch = 8'h6E; // n
					3'd3:    ch = 8'h64; // d
					default: ch = 8'h00;
				endcase
			end
			2'd1: begin
				case (pos)
					3'd0:    ch = 8'h72; // r
					3'd1:    ch = 8'h65; // e
					3'd2:    ch = 8'h63; // c
					3'd3:    ch = 8'h65; // e
					3'd4:    ch = 8'h69; // i
					3'd5:    ch = 8'h76; // v
					3'd6:    ch = 8'h65; // e
					default: ch = 8'h00;
				endcase
			end
			2'd2: begin
				case (pos)
					3'd0:    ch = 8'h73; // s
					3'd1:    ch = 8'h74; // t
					3'd2:    ch = 8'h6F; // o
					3'd3:    ch = 8'h70; // p
					default: ch = 8'h00;
				endcase
			end
			2'd3: begin
				case (pos)
					3'd0:    ch = 8'h71; // q
					3'd1:    ch = 8'h75; // u
					3'd2:    ch = 8'h65; // e
					3'd3:    ch = 8'h72; // r
					3'd4:    ch = 8'h79; // y
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ----- sv/txcmd_if.sv -----
// Valid/ready channel interfaces of the text command field parser.
// Depends on nothing; payload widths follow the message byte and result fields.
interface txcmd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       last_byte;

	modport source (output valid, output byte_value, output last_byte, input ready);
	modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface txcmd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command_code;
	logic [31:0] frequency_hz;
	logic [31:0] duration_value;

	modport source (output valid, output command_code, output frequency_hz,
		output duration_value, input ready);
	modport sink   (input valid, input command_code, input frequency_hz,
		input duration_value, output ready);
endinterface

// ----- sv/txcmd_scanner.sv -----
// Per-byte token scanner: keyword match, digit gathering, unit detection.
// Depends on txcmd_pkg. Updates its state on every accepted beat.
module txcmd_scanner #(
	parameter int MAX_MESSAGE_LEN = txcmd_pkg::MAX_MESSAGE_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              byte_value,
	input  logic                    last_byte,
	output txcmd_pkg::txcmd_result_t result
);
	import txcmd_pkg::*;

	localparam int CNT_W = $clog2(MAX_MESSAGE_LEN + 1);

	logic [CNT_W-1:0] byte_count_q, n_count;
	logic [1:0]       seg_q, n_seg;
	logic             in_tok_q, t_in_tok;
	logic [3:0]       flags_q, t_flags;
	logic [3:0]       cpos_q, t_cpos;
	logic [31:0]      acc_q, t_acc;
	logic [15:0]      recent_q, t_recent;
	logic [1:0]       unit_q, t_unit;
	logic [2:0]       cmd_q, n_cmd, code;
	logic [31:0]      freq_q, n_freq;
	logic [1:0]       funit_q, n_funit;
	logic [31:0]      dur_q, n_dur;
	logic             ended_q, n_ended;
	logic             take, sep, commit, bad_len;

	// Advance token state for one byte, then commit on a separator or the final byte
	always_comb begin
		n_count = (byte_count_q < CNT_W'(MAX_MESSAGE_LEN)) ? byte_count_q + 1'b1 : byte_count_q;
		sep     = (byte_value == CH_NUL) || (byte_value == CH_SEP);
		take    = !ended_q && !sep;
		n_ended = ended_q || (byte_value == CH_NUL);

		t_in_tok = in_tok_q;
		t_flags  = flags_q;
		t_cpos   = cpos_q;
		t_acc    = acc_q;
		t_recent = recent_q;
		t_unit   = unit_q;

		if (take) begin
			t_in_tok = 1'b1;
			if (seg_q == SEG_CMD) begin
				for (int k = 0; k < NUM_KW; k++) begin
					if (cpos_q >= kw_len(2'(k)) || kw_char(2'(k), cpos_q[2:0]) != byte_value)
						t_flags[k] = 1'b0;
				end
			end
			if ((seg_q == SEG_FREQ || seg_q == SEG_DUR) &&
				byte_value >= CH_0 && byte_value <= CH_9) begin
				t_acc = (acc_q << 3) + (acc_q << 1) + {24'd0, byte_value - CH_0};
			end
			if (seg_q == SEG_FREQ && byte_value == CH_Z && recent_q[7:0] == CH_H) begin
				if (recent_q[15:8] == CH_K)
					t_unit[UNIT_KHZ_BIT] = 1'b1;
				else if (recent_q[15:8] == CH_M)
					t_unit[UNIT_MHZ_BIT] = 1'b1;
			end
			t_recent = {recent_q[7:0], byte_value};
			if (cpos_q != 4'hF)
				t_cpos = cpos_q + 4'd1;
		end

		// Keyword decode of the first token
		code = CMD_NONE;
		for (int k = 0; k < NUM_KW; k++) begin
			if (t_flags[k] && t_cpos == kw_len(2'(k)))
				code = kw_code(2'(k));
		end

		commit = !ended_q && (sep || last_byte) && t_in_tok;
		n_cmd   = cmd_q;
		n_freq  = freq_q;
		n_funit = funit_q;
		n_dur   = dur_q;
		n_seg   = seg_q;
		if (commit) begin
			case (seg_q)
				SEG_CMD:  n_cmd = code;
				SEG_FREQ: begin
					n_freq  = t_acc;
					n_funit = t_unit;
				end
				SEG_DUR:  n_dur = t_acc;
				default:  n_cmd = cmd_q;
			endcase
			if (seg_q != SEG_DONE)
				n_seg = seg_q + 2'd1;
		end

		// Build the result; defaults for a message of bad length
		bad_len = (n_count < CNT_W'(MIN_MESSAGE_LEN)) || (n_count >= CNT_W'(MAX_MESSAGE_LEN));
		if (bad_len) begin
			result.command_code   = CMD_NONE;
			result.freq_raw       = 32'd1;
			result.freq_unit      = 2'b00;
			result.duration_value = 32'd1;
		end else begin
			result.command_code   = n_cmd;
			result.freq_raw       = n_freq;
			result.freq_unit      = n_funit;
			result.duration_value = n_dur;
		end
	end

	// Hold state; update on each beat, clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			seg_q        <= SEG_CMD;
			in_tok_q     <= 1'b0;
			flags_q      <= 4'hF;
			cpos_q       <= 4'd0;
			acc_q        <= 32'd0;
			recent_q     <= 16'd0;
			unit_q       <= 2'b00;
			cmd_q        <= CMD_NONE;
			freq_q       <= 32'd1;
			funit_q      <= 2'b00;
			dur_q        <= 32'd1;
			ended_q      <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				byte_count_q <= '0;
				seg_q        <= SEG_CMD;
				in_tok_q     <= 1'b0;
				flags_q      <= 4'hF;
				cpos_q       <= 4'd0;
				acc_q        <= 32'd0;
				recent_q     <= 16'd0;
				unit_q       <= 2'b00;
				cmd_q        <= CMD_NONE;
				freq_q       <= 32'd1;
				funit_q      <= 2'b00;
				dur_q        <= 32'd1;
				ended_q      <= 1'b0;
			end else begin
				byte_count_q <= n_count;
				seg_q        <= n_seg;
				cmd_q        <= n_cmd;
				freq_q       <= n_freq;
				funit_q      <= n_funit;
				dur_q        <= n_dur;
				ended_q      <= n_ended;
				if (commit) begin
					in_tok_q <= 1'b0;
					flags_q  <= 4'hF;
					cpos_q   <= 4'd0;
					acc_q    <= 32'd0;
					recent_q <= 16'd0;
					unit_q   <= 2'b00;
				end else begin
					in_tok_q <= t_in_tok;
					flags_q  <= t_flags;
					cpos_q   <= t_cpos;
					acc_q    <= t_acc;
					recent_q <= t_recent;
					unit_q   <= t_unit;
				end
			end
		end
	end

endmodule

// ----- sv/text_command_field_parser.sv -----
// Text command field parser: top level with result pipeline and frequency scaling.
// Depends on txcmd_pkg, txcmd_if and txcmd_scanner.
//
// Usage: message bytes arrive on cmd_in, one per beat, last_byte set on the
// final byte. Tokens are split on underscores; the first picks the command,
// the second gives the frequency (scaled for khz or mhz), the third the
// duration. One result leaves on res_out for each message, none for other bytes.
// Throughput: one byte per cycle while cmd_in is ready. The scanner updates
// its state on the beat itself; the final byte's result passes through the
// result register, then the scaling multiplier and output register.
// Stall: while res_out is not ready, the output register holds and one more
// result may wait in the result register; cmd_in keeps taking bytes until
// that register is full, then drops ready.
// Reset: arst_n clears the parser state and empties both registers.
module text_command_field_parser #(
	parameter int MAX_MESSAGE_LEN = txcmd_pkg::MAX_MESSAGE_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	txcmd_in_if.sink       cmd_in,
	txcmd_out_if.source    res_out
);
	import txcmd_pkg::*;

	txcmd_result_t scan_res, res_s1;
	logic          v_s1, out_v_q, out_free, accept;
	logic [2:0]    cmd_q;
	logic [31:0]   freq_q, dur_q;
	logic [19:0]   scale;
	logic [51:0]   product;

	assign out_free     = !out_v_q || res_out.ready;
	assign cmd_in.ready = !v_s1 || out_free;
	assign accept       = cmd_in.valid && cmd_in.ready;

	txcmd_scanner #(
		.MAX_MESSAGE_LEN(MAX_MESSAGE_LEN)
	) u_scanner (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.byte_value (cmd_in.byte_value),
		.last_byte  (cmd_in.last_byte),
		.result     (scan_res)
	);

	// Pick the unit scale; khz wins over mhz
	always_comb begin
		if (res_s1.freq_unit[UNIT_KHZ_BIT])
			scale = SCALE_KHZ;
		else if (res_s1.freq_unit[UNIT_MHZ_BIT])
			scale = SCALE_MHZ;
		else
			scale = SCALE_ONE;
		product = res_s1.freq_raw * scale;
	end

	// Capture the result on the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_in.ready) begin
			v_s1 <= accept && cmd_in.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd_in.last_byte)
			res_s1 <= scan_res;
	end

	// Advance into the output register when it is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			cmd_q  <= res_s1.command_code;
			freq_q <= product[31:0];
			dur_q  <= res_s1.duration_value;
		end
	end

	assign res_out.valid          = out_v_q;
	assign res_out.command_code   = cmd_q;
	assign res_out.frequency_hz   = freq_q;
	assign res_out.duration_value = dur_q;

endmodule
